@@ rtl/core/apm_pkg.sv @@
// Shared types and constants for the ADC pair moving average meter.
package apm_pkg;

   localparam int unsigned CSR_ADDR_BITS = 3;

   // configuration register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_WINDOW = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ZERO   = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CGAIN  = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_VGAIN  = 3'd3;

   localparam logic [6:0]  RST_WINDOW = 7'd16;
   localparam logic [19:0] RST_CGAIN  = 20'd65536;
   localparam logic [27:0] RST_VGAIN  = 28'd53;

   // control from the sequencer to the serial divider and multiplier
   typedef struct packed {
      logic start_div;
      logic start_mul;
   } ctl_type;

endpackage

@@ rtl/core/adc_pair_moving_average_meter.sv @@
// Top level of the ADC pair moving average meter.
//
// Usage: a word on the req_ channel carries one ADC pair for the current
// channel (0) or the voltage channel (1). It is accepted when req_valid is
// high and req_stall is low. Each word gives one rsp_ word with the P, N and
// difference averages of that channel in Q.8 plus the latest current,
// voltage and power values.
// One word at a time: req_stall is high from acceptance until the result
// word is loaded at the output step. The time goes to the ring read and
// update states, three serial divides (one quotient bit a cycle over the
// 27-bit Q.8 sum at defaults), a gain multiply over the 28 gain bits, for
// voltage a power multiply over the 24 voltage bits, and the output step.
// The rings are RAMs whose stale entries are never used: the fill count
// limits use to entries written since the last clear, so reset costs no
// clearing pass. Any csr_ write to a listed register clears sums, indexes,
// fill counts and the latest values.
// When the receiver stalls, the result word holds at rsp_; the next req_
// word is still taken and worked, and waits at the output step until then.
module adc_pair_moving_average_meter #(
   parameter int unsigned MAX_WINDOW  = 64,
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_channel,
   input  logic [11:0]          req_raw_pos,
   input  logic [11:0]          req_raw_neg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_channel_out,
   output logic [19:0]          rsp_avg_pos,
   output logic [19:0]          rsp_avg_neg,
   output logic signed [20:0]   rsp_avg_diff,
   output logic signed [25:0]   rsp_current_value,
   output logic [23:0]          rsp_voltage_value,
   output logic signed [47:0]   rsp_power_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [apm_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int unsigned DB  = SAMPLE_BITS < 12 ? SAMPLE_BITS : 12; // reading bits used
   localparam int unsigned IW  = $clog2(MAX_WINDOW) > 0 ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned FW  = $clog2(MAX_WINDOW + 1);
   localparam int unsigned SW  = DB + FW;            // running sum width
   localparam int unsigned NW  = SW + 8;             // Q.8 numerator
   localparam int unsigned AW  = 22;                 // signed multiplier operand
   localparam int unsigned MBW = 28;
   localparam int unsigned PW  = AW + MBW + 1;

   localparam logic signed [49:0] POW_MAX = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] POW_MIN = -50'sh0_8000_0000_0000;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_UPDATE, S_DIVP, S_DIVN, S_DIVD,
      S_MULC, S_MULV, S_MULP, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [6:0]         win_cfg_ff;
   logic signed [20:0] zero_ff;
   logic [19:0]        cgain_ff;
   logic [27:0]        vgain_ff;
   logic               clear;

   // per-channel running state and the latest values
   logic [SW-1:0] psum_ff [2];
   logic [SW-1:0] nsum_ff [2];
   logic [IW-1:0] idx_ff  [2];
   logic [FW-1:0] fill_ff [2];
   logic signed [25:0] cur_ff;
   logic [23:0]        volt_ff;
   logic signed [47:0] pow_ff;

   // item registers
   logic               ch_ff;
   logic [DB-1:0]      p_ff, n_ff;
   logic [IW-1:0]      slot_ff;
   logic [SW-1:0]      ps_ff, ns_ff;
   logic [FW-1:0]      cnt_ff;
   logic               dneg_ff;
   logic [19:0]        ap_ff, an_ff;
   logic signed [20:0] ad_ff;
   logic               rsp_valid_ff;

   // result word registers
   logic               out_ch_ff;
   logic [19:0]        out_ap_ff, out_an_ff;
   logic signed [20:0] out_ad_ff;
   logic signed [25:0] out_cur_ff;
   logic [23:0]        out_volt_ff;
   logic signed [47:0] out_pow_ff;
   logic               out_load;

   // effective window
   logic [FW-1:0] win;
   always_comb begin
      if (win_cfg_ff == 7'd0) begin
         win = FW'(1);
      end else if ({25'd0, win_cfg_ff} > MAX_WINDOW) begin
         win = FW'(MAX_WINDOW);
      end else begin
         win = FW'(win_cfg_ff);
      end
   end

   // ring RAMs, one row per channel
   logic              ram_we;
   logic [IW:0]       ram_addr;
   logic [DB-1:0]     prd, nrd;
   logic [IW-1:0]     idx_cur;
   assign idx_cur  = ({{(32-IW){1'b0}}, idx_ff[req_channel]} >= 32'(win)) ? '0
                     : idx_ff[req_channel];
   assign ram_we   = (state_ff == S_UPDATE);
   assign ram_addr = (state_ff == S_IDLE) ? {req_channel, idx_cur} : {ch_ff, slot_ff};

   apm_ram #(.WIDTH(DB), .DEPTH(2 * (1 << IW))) u_pos_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(p_ff), .rd_data(prd));
   apm_ram #(.WIDTH(DB), .DEPTH(2 * (1 << IW))) u_neg_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(n_ff), .rd_data(nrd));

   // shared divider
   apm_pkg::ctl_type ctl;
   logic [NW-1:0] div_num, quot;
   logic          div_done, mul_done;
   logic [SW:0]   dmag;
   assign dmag = ps_ff >= ns_ff ? {1'b0, ps_ff - ns_ff} : {1'b0, ns_ff - ps_ff};
   always_comb begin
      case (state_ff)
         S_DIVP:  div_num = {ps_ff, 8'd0};
         S_DIVN:  div_num = {ns_ff, 8'd0};
         default: div_num = {dmag[SW-1:0], 8'd0};
      endcase
   end
   apm_div #(.NW(NW), .DW(FW)) u_div (
      .clock(clock), .reset(reset), .start(ctl.start_div), .numer(div_num),
      .denom(cnt_ff), .done(div_done), .quot(quot));

   // shared multiplier
   logic signed [AW-1:0]  mul_a;
   logic [MBW-1:0]        mul_b;
   logic signed [PW-1:0]  prod;
   always_comb begin
      case (state_ff)
         S_MULC: begin
            mul_a = AW'(ad_ff) - AW'(zero_ff);
            mul_b = MBW'(cgain_ff);
         end
         S_MULV: begin
            mul_a = ad_ff > 0 ? AW'(ad_ff) : '0;
            mul_b = vgain_ff;
         end
         default: begin
            mul_a = cur_ff[AW-1:0];
            mul_b = MBW'(volt_ff);
         end
      endcase
   end
   apm_mul #(.AW(AW), .BW(MBW)) u_mul (
      .clock(clock), .reset(reset), .start(ctl.start_mul), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(prod));

   // gain product back to Q.8, rounding toward minus infinity
   logic signed [49:0] pow_full;
   logic signed [PW-1:0] shr;
   assign shr = prod >>> 16;

   // sequencer starts
   logic start_flag_ff;
   assign ctl.start_div = start_flag_ff &&
      (state_ff == S_DIVP || state_ff == S_DIVN || state_ff == S_DIVD);
   assign ctl.start_mul = start_flag_ff &&
      (state_ff == S_MULC || state_ff == S_MULV || state_ff == S_MULP);

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign clear     = csr_valid && (csr_index <= apm_pkg::REG_VGAIN);
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // power multiplier: voltage bits against the shifted current
   logic signed [49:0] pc_a_ff;
   logic signed [49:0] pacc_ff;
   logic [4:0]         pcnt_ff;
   logic [23:0]        pb_ff;
   assign pow_full = pacc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         start_flag_ff <= 1'b0;
         win_cfg_ff    <= apm_pkg::RST_WINDOW;
         zero_ff       <= '0;
         cgain_ff      <= apm_pkg::RST_CGAIN;
         vgain_ff      <= apm_pkg::RST_VGAIN;
         for (int c = 0; c < 2; c++) begin
            psum_ff[c] <= '0;
            nsum_ff[c] <= '0;
            idx_ff[c]  <= '0;
            fill_ff[c] <= '0;
         end
         cur_ff  <= '0;
         volt_ff <= '0;
         pow_ff  <= '0;
         pcnt_ff <= '0;
      end else begin
         start_flag_ff <= 1'b0;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               apm_pkg::REG_WINDOW: win_cfg_ff <= csr_data[6:0];
               apm_pkg::REG_ZERO:   zero_ff    <= csr_data[20:0];
               apm_pkg::REG_CGAIN:  cgain_ff   <= csr_data[19:0];
               apm_pkg::REG_VGAIN:  vgain_ff   <= csr_data[27:0];
               default: ;
            endcase
            if (clear) begin
               for (int c = 0; c < 2; c++) begin
                  psum_ff[c] <= '0;
                  nsum_ff[c] <= '0;
                  idx_ff[c]  <= '0;
                  fill_ff[c] <= '0;
               end
               cur_ff  <= '0;
               volt_ff <= '0;
               pow_ff  <= '0;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  ch_ff    <= req_channel;
                  p_ff     <= req_raw_pos[DB-1:0];
                  n_ff     <= req_raw_neg[DB-1:0];
                  slot_ff  <= idx_cur;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_UPDATE;
            S_UPDATE: begin
               // drop the oldest sample once the ring is full
               logic [SW-1:0] ps, ns;
               logic [FW-1:0] fc;
               ps = psum_ff[ch_ff];
               ns = nsum_ff[ch_ff];
               fc = fill_ff[ch_ff];
               if (fc < win) begin
                  fc = fc + FW'(1);
               end else begin
                  ps = ps - SW'(prd);
                  ns = ns - SW'(nrd);
               end
               ps = ps + SW'(p_ff);
               ns = ns + SW'(n_ff);
               psum_ff[ch_ff] <= ps;
               nsum_ff[ch_ff] <= ns;
               fill_ff[ch_ff] <= fc;
               idx_ff[ch_ff]  <= (32'(slot_ff) + 32'd1 >= 32'(win)) ? '0 : slot_ff + IW'(1);
               ps_ff   <= ps;
               ns_ff   <= ns;
               cnt_ff  <= fc;
               dneg_ff <= ns > ps;
               state_ff      <= S_DIVP;
               start_flag_ff <= 1'b1;
            end
            S_DIVP: begin
               if (div_done) begin
                  ap_ff         <= quot[19:0];
                  state_ff      <= S_DIVN;
                  start_flag_ff <= 1'b1;
               end
            end
            S_DIVN: begin
               if (div_done) begin
                  an_ff         <= quot[19:0];
                  state_ff      <= S_DIVD;
                  start_flag_ff <= 1'b1;
               end
            end
            S_DIVD: begin
               if (div_done) begin
                  ad_ff         <= dneg_ff ? -$signed(quot[20:0]) : $signed(quot[20:0]);
                  state_ff      <= ch_ff ? S_MULV : S_MULC;
                  start_flag_ff <= 1'b1;
               end
            end
            S_MULC: begin
               if (mul_done) begin
                  // arithmetic shift floors; then saturate to 26 bits
                  if (shr > $signed(PW'(33554431))) begin
                     cur_ff <= 26'sh1FFFFFF;
                  end else if (shr < -$signed(PW'(33554432))) begin
                     cur_ff <= -26'sh2000000;
                  end else begin
                     cur_ff <= shr[25:0];
                  end
                  state_ff <= S_OUT;
               end
            end
            S_MULV: begin
               if (mul_done) begin
                  logic [23:0] v;
                  v = (shr > $signed(PW'(16777215))) ? 24'hFFFFFF : shr[23:0];
                  volt_ff  <= v;
                  pc_a_ff  <= 50'(cur_ff);
                  pb_ff    <= v;
                  pacc_ff  <= '0;
                  pcnt_ff  <= 5'd24;
                  state_ff <= S_MULP;
               end
            end
            S_MULP: begin
               // voltage bit-serial against the full 26-bit current
               if (pcnt_ff != 5'd0) begin
                  if (pb_ff[0]) begin
                     pacc_ff <= pacc_ff + pc_a_ff;
                  end
                  pc_a_ff <= pc_a_ff <<< 1;
                  pb_ff   <= pb_ff >> 1;
                  pcnt_ff <= pcnt_ff - 5'd1;
               end else begin
                  // saturate to 48 bits signed
                  if (pow_full > POW_MAX) begin
                     pow_ff <= POW_MAX[47:0];
                  end else if (pow_full < POW_MIN) begin
                     pow_ff <= POW_MIN[47:0];
                  end else begin
                     pow_ff <= pow_full[47:0];
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // wait here while the previous word is still held
               if (out_load) begin
                  out_ch_ff   <= ch_ff;
                  out_ap_ff   <= ap_ff;
                  out_an_ff   <= an_ff;
                  out_ad_ff   <= ad_ff;
                  out_cur_ff  <= cur_ff;
                  out_volt_ff <= volt_ff;
                  out_pow_ff  <= pow_ff;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_out   = out_ch_ff;
   assign rsp_avg_pos       = out_ap_ff;
   assign rsp_avg_neg       = out_an_ff;
   assign rsp_avg_diff      = out_ad_ff;
   assign rsp_current_value = out_cur_ff;
   assign rsp_voltage_value = out_volt_ff;
   assign rsp_power_value   = out_pow_ff;

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_avg_diff) &&
      $stable(rsp_power_value)) else $error("stalled result changed");
   // divider and multiplier are never started together
   assert property (@(posedge clock) disable iff (reset)
      !(ctl.start_div && ctl.start_mul)) else $error("shared units started together");
   // a result appears only after the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT)) else $error("stray result");

endmodule

@@ rtl/core/apm_ram.sv @@
// Generic single-port RAM with registered read.
module apm_ram #(
   parameter int unsigned WIDTH = 12,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;

endmodule

@@ rtl/core/apm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module apm_div #(
   parameter int unsigned NW = 32,
   parameter int unsigned DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int unsigned CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW+1:0] diff;

   // shift one numerator bit into the remainder and try a subtract
   always_comb begin
      trial   = {r_ff[DW-1:0], q_ff[NW-1]};
      diff    = {1'b0, trial} - {2'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = numer;
         r_in    = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[DW+1]) begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end else begin
            r_in = diff[DW:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) begin
         d_ff <= denom;
      end
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

@@ rtl/core/apm_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, signed a, unsigned b.
module apm_mul #(
   parameter int unsigned AW = 32,
   parameter int unsigned BW = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [AW-1:0]  a,
   input  logic        [BW-1:0]  b,
   output logic                  done,
   output logic signed [AW+BW:0] prod
);

   localparam int unsigned CW = $clog2(BW + 1);

   logic signed [AW+BW:0] acc_ff, acc_in, a_ff, a_in;
   logic [BW-1:0]         b_ff, b_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;

   // add the shifted multiplicand for each set bit of the unsigned factor
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = (AW+BW+1)'(a);
         b_in    = b;
         cnt_in  = CW'(BW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff <<< 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
